// ----- rtl/core/tir_pkg.sv -----
// Package with the types, constants and saturation helper of the trapezoid integrator.
`timescale 1ns / 1ps
`default_nettype none

package tir_pkg;

	localparam int unsigned CFG_W      = 11;
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned DIV_W      = 33;
	localparam int unsigned DIV_STEPS  = 33;
	localparam int unsigned DIV_CNT_W  = 6;
	localparam int unsigned XACC_W     = 44;

	localparam logic [CFG_W-1:0] MAX_STEPS     = 11'd1024;
	localparam logic [CFG_W-1:0] STEP_RESET    = 11'd64;
	localparam logic [DIV_W-1:0] TWO_POW_32    = 33'h1_0000_0000;
	localparam logic signed [63:0] S32_MAX_64  = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN_64  = -64'sd2147483648;
	localparam logic signed [63:0] Q_ONE_64    = 64'sd65536;
	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic signed [DATA_W-1:0] lower_bound;
		logic signed [DATA_W-1:0] upper_bound;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] area;
		logic                     pole_hit;
		logic                     saturated;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic                     flag;
		logic signed [DATA_W-1:0] val;
	} sat_t;

	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > S32_MAX_64) begin
			r.flag = 1'b1;
			r.val  = S32_MAX;
		end else if (v < S32_MIN_64) begin
			r.flag = 1'b1;
			r.val  = 32'sh8000_0000;
		end else begin
			r.flag = 1'b0;
			r.val  = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tir_div.sv -----
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
`timescale 1ns / 1ps
`default_nettype none

module tir_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tir_pkg::div_req_t req,
	output tir_pkg::div_rsp_t      rsp
);
	import tir_pkg::*;

	logic [DIV_W-1:0]     dvd_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DATA_W-1:0]    dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_W:0]       trial;
	logic                 ge;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign ge    = trial >= {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_W'(trial - {2'b00, dsr_q}) : trial[DIV_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("Divider finished without running.");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("Divider started while busy.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q < DIV_CNT_W'(DIV_STEPS))
		else $error("Divider step count out of range.");

endmodule

`default_nettype wire

// ----- rtl/core/trapezoid_integrator_reciprocal.sv -----
// Top level of the trapezoid-rule integrator of 1/(x+1) in signed Q16.16.
// n is the clamped step count. A new item is taken only once the last is finished. The step width
// and each of the n + 1 node reciprocals take a pass of a shared bit-serial divider; a node on
// the pole skips its pass.
// A finished result waits in an output register while the next item is taken.
// Reset is asynchronous and active low; it empties the block and sets the step count to 64.
`timescale 1ns / 1ps
`default_nettype none

module trapezoid_integrator_reciprocal (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [10:0]              cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire tir_pkg::in_item_t        in_item,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output tir_pkg::out_item_t            out_item
);
	import tir_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_SETUP = 11'b000_0000_0010,
		S_DIV_H = 11'b000_0000_0100,
		S_NODE  = 11'b000_0000_1000,
		S_PREP  = 11'b000_0001_0000,
		S_DIV_F = 11'b000_0010_0000,
		S_PAIR  = 11'b000_0100_0000,
		S_MUL   = 11'b000_1000_0000,
		S_ACC   = 11'b001_0000_0000,
		S_SUM   = 11'b010_0000_0000,
		S_DONE  = 11'b100_0000_0000
	} state_t;

	state_t                    state_q;
	logic [CFG_W-1:0]          step_count_q;
	logic [CFG_W-1:0]          n_q;
	logic [CFG_W-1:0]          i_q;
	logic signed [DATA_W-1:0]  lo_q;
	logic signed [DATA_W-1:0]  up_q;
	logic                      d_neg_q;
	logic                      p_neg_q;
	logic signed [DATA_W-1:0]  h_q;
	logic signed [DATA_W-1:0]  hh_q;
	logic signed [XACC_W-1:0]  x_acc_q;
	logic signed [DATA_W-1:0]  x_q;
	logic signed [DATA_W-1:0]  f_q;
	logic signed [DATA_W-1:0]  f_prev_q;
	logic signed [DATA_W-1:0]  pair_q;
	logic signed [63:0]        prod_q;
	logic signed [DATA_W-1:0]  term_q;
	logic signed [DATA_W-1:0]  sum_q;
	logic                      pole_q;
	logic                      sat_q;
	logic                      out_valid_q;
	out_item_t                 out_q;

	logic [CFG_W-1:0]          n_clamp;
	logic signed [DIV_W-1:0]   d_s;
	logic [DIV_W-1:0]          d_mag;
	logic signed [63:0]        q_ext;
	logic signed [63:0]        q_sgn;
	sat_t                      q_sat;
	sat_t                      x_sat;
	sat_t                      p_sat;
	logic [DATA_W-1:0]         p_mag;
	sat_t                      pair_sat;
	logic signed [63:0]        prod_rnd;
	sat_t                      term_sat;
	sat_t                      sum_sat;
	logic signed [XACC_W-1:0]  x_next;
	logic                      accept;
	logic                      out_free;
	div_req_t                  div_req;
	div_rsp_t                  div_rsp;

	assign in_ready  = state_q == S_IDLE;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		if (step_count_q == '0) begin
			n_clamp = CFG_W'(1);
		end else if (step_count_q > MAX_STEPS) begin
			n_clamp = MAX_STEPS;
		end else begin
			n_clamp = step_count_q;
		end
		d_s      = DIV_W'($signed(up_q)) - DIV_W'($signed(lo_q));
		d_mag    = d_s[DIV_W-1] ? DIV_W'(-d_s) : DIV_W'(d_s);
		q_ext    = $signed({31'b0, div_rsp.quotient});
		q_sgn    = ((state_q == S_DIV_H) ? d_neg_q : p_neg_q) ? -q_ext : q_ext;
		q_sat    = sat32(q_sgn);
		x_sat    = sat32(64'(x_acc_q));
		p_sat    = sat32(64'(x_q) + Q_ONE_64);
		p_mag    = p_sat.val[DATA_W-1] ? DATA_W'(-p_sat.val) : DATA_W'(p_sat.val);
		pair_sat = sat32(64'(f_prev_q) + 64'(f_q));
		prod_rnd = prod_q + (prod_q[63] ? 64'sd65535 : 64'sd0);
		term_sat = sat32(prod_rnd >>> 16);
		sum_sat  = sat32(64'(sum_q) + 64'(term_q));
		x_next   = x_acc_q + XACC_W'(h_q);
	end

	always_comb begin
		div_req.start    = (state_q == S_SETUP) || (state_q == S_PREP && p_sat.val != '0);
		div_req.dividend = (state_q == S_SETUP) ? d_mag : TWO_POW_32;
		div_req.divisor  = (state_q == S_SETUP) ? DATA_W'(n_q) : p_mag;
	end

	tir_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= STEP_RESET;
		end else if (cfg_we) begin
			step_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			i_q         <= '0;
			n_q         <= CFG_W'(1);
			pole_q      <= 1'b0;
			sat_q       <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						n_q     <= n_clamp;
						i_q     <= '0;
						pole_q  <= 1'b0;
						sat_q   <= 1'b0;
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					state_q <= S_DIV_H;
				end
				S_DIV_H: begin
					if (div_rsp.done) begin
						sat_q   <= sat_q | q_sat.flag;
						state_q <= S_NODE;
					end
				end
				S_NODE: begin
					sat_q   <= sat_q | x_sat.flag;
					state_q <= S_PREP;
				end
				S_PREP: begin
					sat_q <= sat_q | p_sat.flag;
					if (p_sat.val == '0) begin
						pole_q  <= 1'b1;
						state_q <= S_PAIR;
					end else begin
						state_q <= S_DIV_F;
					end
				end
				S_DIV_F: begin
					if (div_rsp.done) begin
						sat_q   <= sat_q | q_sat.flag;
						state_q <= S_PAIR;
					end
				end
				S_PAIR: begin
					if (i_q == '0) begin
						i_q     <= CFG_W'(1);
						state_q <= S_NODE;
					end else begin
						sat_q   <= sat_q | pair_sat.flag;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					sat_q   <= sat_q | term_sat.flag;
					state_q <= S_SUM;
				end
				S_SUM: begin
					sat_q <= sat_q | sum_sat.flag;
					if (i_q == n_q) begin
						state_q <= S_DONE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_NODE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q  <= in_item.lower_bound;
			up_q  <= in_item.upper_bound;
			sum_q <= '0;
		end
		if (state_q == S_SETUP) begin
			d_neg_q <= d_s[DIV_W-1];
		end
		if (state_q == S_DIV_H && div_rsp.done) begin
			h_q     <= q_sat.val;
			x_acc_q <= XACC_W'(lo_q);
		end
		if (state_q == S_NODE) begin
			x_q  <= x_sat.val;
			hh_q <= (h_q + $signed({31'b0, h_q[DATA_W-1]})) >>> 1;
		end
		if (state_q == S_PREP) begin
			p_neg_q <= p_sat.val[DATA_W-1];
			if (p_sat.val == '0) begin
				f_q <= S32_MAX;
			end
		end
		if (state_q == S_DIV_F && div_rsp.done) begin
			f_q <= q_sat.val;
		end
		if (state_q == S_PAIR) begin
			f_prev_q <= f_q;
			pair_q   <= pair_sat.val;
			if (i_q == '0) begin
				x_acc_q <= x_next;
			end
		end
		if (state_q == S_MUL) begin
			prod_q <= 64'(hh_q) * 64'(pair_q);
		end
		if (state_q == S_ACC) begin
			term_q <= term_sat.val;
		end
		if (state_q == S_SUM) begin
			sum_q <= sum_sat.val;
			if (i_q != n_q) begin
				x_acc_q <= x_next;
			end
		end
		if (state_q == S_DONE && out_free) begin
			out_q.area      <= sum_q;
			out_q.pole_hit  <= pole_q;
			out_q.saturated <= sat_q;
		end
	end

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> i_q <= n_q)
		else $error("Node index passed the step count.");

	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_SETUP)
		else $error("Accepted item did not start the step-width division.");

	a_steps_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> (n_q != '0 && n_q <= MAX_STEPS))
		else $error("Step count out of range during work.");

	a_recip_return: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV_F && div_rsp.done) |=> state_q == S_PAIR)
		else $error("Reciprocal result was not used.");

endmodule

`default_nettype wire
